>>> rtl/height_map_max_rasterizer_top_assert.svh
// Assertion macros used by the height map rasterizer controller (hmr_ctrl).
// Expects clk_i and rst_ni in the scope of the module that uses them.
`ifndef HEIGHT_MAP_MAX_RASTERIZER_TOP_ASSERT_SVH
`define HEIGHT_MAP_MAX_RASTERIZER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define HMR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define HMR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/hmr_pkg.sv
// Shared types and constants of the height map max rasterizer.
// Used by hmr_ctrl, hmr_dp, height_map_max_rasterizer_top and tb_top; no dependencies.
package hmr_pkg;

  // Operation codes carried in the input tuser
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_QUERY  = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_OFFSET  = 3'd0,
    REG_Y_OFFSET  = 3'd1,
    REG_X_STEP    = 3'd2,
    REG_Y_STEP    = 3'd3,
    REG_FLOOR     = 3'd4,
    REG_COLS_USED = 3'd5,
    REG_ROWS_USED = 3'd6
  } cfg_reg_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_LOOKUP,
    ST_MEM,
    ST_CLEAR,
    ST_FINISH
  } state_e;

  // Divider: one quotient bit per step over a 33-bit dividend
  localparam int unsigned DIV_STEPS = 33;
  localparam int unsigned CNT_W     = 6;

  // -1.0 in Q16.16
  localparam logic [31:0] Q16_MINUS_ONE = 32'hFFFF_0000;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;      // latch a new beat
    logic prep;      // form the dividends
    logic div_step;  // one step of both dividers
    logic lookup;    // range check, latch cell indexes
    logic mem_rd;    // read the addressed cell
    logic clr_step;  // write one cell of the clear sweep
    logic out_load;  // capture the result, commit an insert
  } hmr_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clr_empty; // no cell in use
    logic clr_last;  // sweep at the last used cell
  } hmr_sts_t;

endpackage

>>> rtl/hmr_ctrl.sv
// Controller of the height map max rasterizer: sequences one beat at a time.
// Depends on hmr_pkg and height_map_max_rasterizer_top_assert.svh.
`include "height_map_max_rasterizer_top_assert.svh"

module hmr_ctrl
  import hmr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_valid_i,
  input  logic [1:0] s_op_i,
  output logic      s_ready_o,
  input  logic      m_ready_i,
  output logic      m_valid_o,
  output hmr_cmd_t  cmd_o,
  input  hmr_sts_t  sts_i
);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             accept;
  logic             out_free;

  assign s_ready_o = (state_q == ST_IDLE);
  assign m_valid_o = out_valid_q;
  assign accept    = s_valid_i && s_ready_o;
  assign out_free  = !out_valid_q || m_ready_i;

  // State, step counter and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          case (op_e'(s_op_i))
            OP_CLEAR: state_d = ST_CLEAR;
            OP_READ:  state_d = ST_LOOKUP;
            default:  state_d = ST_PREP;
          endcase
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        cnt_d      = '0;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        state_d      = ST_MEM;
      end
      ST_MEM: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = ST_FINISH;
      end
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_empty || sts_i.clr_last) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // Hold until the output register can take the result
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Result valid: set on load, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  `HMR_ASSERT_IMP(a_load_when_free, cmd_o.out_load, (!out_valid_q || m_ready_i), "result overwritten")
  `HMR_ASSERT_IMP(a_div_cnt_bound, state_q == ST_DIV, cnt_q < CNT_W'(DIV_STEPS), "divider overran")
  `HMR_ASSERT_IMP(a_valid_from_finish, $rose(out_valid_q), $past(state_q) == ST_FINISH, "stray result")
  `HMR_ASSERT_NXT(a_busy_after_accept, accept, state_q != ST_IDLE, "beat accepted but no work")

endmodule

>>> rtl/hmr_dp.sv
// Datapath of the height map max rasterizer: configuration registers, two
// bit-serial dividers, range check, cell memory and result register. Uses hmr_pkg.
module hmr_dp
  import hmr_pkg::*;
#(
  parameter int unsigned GRID_X_CELLS = 256,
  parameter int unsigned GRID_Y_CELLS = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  hmr_cmd_t              cmd_i,
  output hmr_sts_t              sts_o,
  input  logic [1:0]            op_i,
  input  logic signed [31:0]    x_pos_i,
  input  logic signed [31:0]    y_pos_i,
  input  logic signed [31:0]    z_pos_i,
  input  logic [7:0]            cell_x_i,
  input  logic [7:0]            cell_y_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic signed [31:0]    height_out_o,
  output logic                  out_of_range_o
);

  localparam int unsigned XW    = $clog2(GRID_X_CELLS);
  localparam int unsigned YW    = $clog2(GRID_Y_CELLS);
  localparam int unsigned DEPTH = GRID_X_CELLS * GRID_Y_CELLS;
  localparam int unsigned AW    = $clog2(DEPTH);

  // One restoring step: returns {remainder, shifted dividend with new quotient bit}
  function automatic logic [64:0] div_step(logic [31:0] rem, logic [32:0] num,
                                           logic [30:0] den);
    logic [32:0] trial;
    logic [32:0] diff;
    logic        qbit;
    trial = {rem, num[32]};
    diff  = trial - {2'b00, den};
    qbit  = (trial >= {2'b00, den});
    return {(qbit ? diff[31:0] : trial[31:0]), num[31:0], qbit};
  endfunction

  // Configuration
  logic [31:0] x_off_q, y_off_q, floor_q;
  logic [30:0] x_step_q, y_step_q;
  logic [8:0]  cols_used_q, rows_used_q;

  // Beat and divider state
  op_e         op_q;
  logic [31:0] z_q;
  logic [7:0]  cellx_q, celly_q;
  logic [32:0] sx_q, sy_q;
  logic        posx_q, posy_q;
  logic [32:0] nx_q, ny_q;
  logic [31:0] rx_q, ry_q;
  logic [XW-1:0] cx_q;
  logic [YW-1:0] cy_q;
  logic        hit_q;
  logic [31:0] rdata_q;
  logic [31:0] height_q;
  logic        oor_q;
  logic [31:0] mem_q [DEPTH];

  logic [30:0] dx, dy;
  logic [33:0] ux, uy;
  logic [33:0] qx_full, qy_full;
  logic        okx, oky;
  logic [64:0] stx, sty;
  logic [AW-1:0] addr;
  logic        mem_we;
  logic [31:0] mem_wdata;
  logic        clr_last_y;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_off_q     <= '0;
      y_off_q     <= '0;
      x_step_q    <= 31'd65536;
      y_step_q    <= 31'd65536;
      floor_q     <= '0;
      cols_used_q <= 9'd256;
      rows_used_q <= 9'd256;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_X_OFFSET:  x_off_q     <= cfg_data_i;
        REG_Y_OFFSET:  y_off_q     <= cfg_data_i;
        REG_X_STEP:    x_step_q    <= cfg_data_i[30:0];
        REG_Y_STEP:    y_step_q    <= cfg_data_i[30:0];
        REG_FLOOR:     floor_q     <= cfg_data_i;
        REG_COLS_USED: cols_used_q <= cfg_data_i[8:0];
        REG_ROWS_USED: rows_used_q <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // Zero step acts as one; clamp used counts to the grid
  assign dx = (x_step_q == '0) ? 31'd1 : x_step_q;
  assign dy = (y_step_q == '0) ? 31'd1 : y_step_q;
  assign ux = (34'(cols_used_q) > 34'(GRID_X_CELLS)) ? 34'(GRID_X_CELLS) : 34'(cols_used_q);
  assign uy = (34'(rows_used_q) > 34'(GRID_Y_CELLS)) ? 34'(GRID_Y_CELLS) : 34'(rows_used_q);

  assign stx = div_step(rx_q, nx_q, dx);
  assign sty = div_step(ry_q, ny_q, dy);

  // Cell candidates: ceil(s/d) = floor((s-1)/d)+1 for s>0, else inside only at zero
  always_comb begin
    if (op_q == OP_READ) begin
      qx_full = 34'(cellx_q);
      qy_full = 34'(celly_q);
      okx     = qx_full < ux;
      oky     = qy_full < uy;
    end else begin
      qx_full = posx_q ? (34'(nx_q) + 34'd1) : 34'd0;
      qy_full = posy_q ? (34'(ny_q) + 34'd1) : 34'd0;
      okx     = (posx_q || (nx_q == '0)) && (qx_full < ux);
      oky     = (posy_q || (ny_q == '0)) && (qy_full < uy);
    end
  end

  // Beat capture, dividend setup, division, lookup and clear sweep
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= op_e'(op_i);
      z_q     <= z_pos_i;
      cellx_q <= cell_x_i;
      celly_q <= cell_y_i;
      sx_q    <= 33'(x_pos_i) + 33'($signed(x_off_q));
      sy_q    <= 33'(y_pos_i) + 33'($signed(y_off_q));
      cx_q    <= '0;
      cy_q    <= '0;
    end
    if (cmd_i.prep) begin
      posx_q <= !sx_q[32] && (sx_q != '0);
      posy_q <= !sy_q[32] && (sy_q != '0);
      nx_q   <= (!sx_q[32] && (sx_q != '0)) ? (sx_q - 33'd1) : (33'd0 - sx_q);
      ny_q   <= (!sy_q[32] && (sy_q != '0)) ? (sy_q - 33'd1) : (33'd0 - sy_q);
      rx_q   <= '0;
      ry_q   <= '0;
    end
    if (cmd_i.div_step) begin
      rx_q <= stx[64:33];
      nx_q <= stx[32:0];
      ry_q <= sty[64:33];
      ny_q <= sty[32:0];
    end
    if (cmd_i.lookup) begin
      hit_q <= okx && oky;
      cx_q  <= qx_full[XW-1:0];
      cy_q  <= qy_full[YW-1:0];
    end
    // Advance the sweep column by column, through the rows of each column
    if (cmd_i.clr_step && !sts_o.clr_empty) begin
      if (clr_last_y) begin
        cy_q <= '0;
        cx_q <= cx_q + XW'(1);
      end else begin
        cy_q <= cy_q + YW'(1);
      end
    end
  end

  assign clr_last_y      = (34'(cy_q) + 34'd1) == uy;
  assign sts_o.clr_empty = (ux == '0) || (uy == '0);
  assign sts_o.clr_last  = clr_last_y && ((34'(cx_q) + 34'd1) == ux);

  // Cell memory: one write and one registered read port
  assign addr      = AW'(cx_q) * AW'(GRID_Y_CELLS) + AW'(cy_q);
  assign mem_we    = (cmd_i.clr_step && !sts_o.clr_empty) ||
                     (cmd_i.out_load && (op_q == OP_INSERT) && hit_q &&
                      ($signed(z_q) > $signed(rdata_q)));
  assign mem_wdata = (op_q == OP_CLEAR) ? floor_q : z_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[addr] <= mem_wdata;
    end
    if (cmd_i.mem_rd) begin
      rdata_q <= mem_q[addr];
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      case (op_q)
        OP_CLEAR: begin
          height_q <= '0;
          oor_q    <= 1'b0;
        end
        OP_INSERT: begin
          height_q <= '0;
          oor_q    <= !hit_q;
        end
        default: begin
          height_q <= hit_q ? rdata_q : Q16_MINUS_ONE;
          oor_q    <= !hit_q;
        end
      endcase
    end
  end

  assign height_out_o   = height_q;
  assign out_of_range_o = oor_q;

endmodule

>>> rtl/height_map_max_rasterizer_top.sv
// Top level of the height map max rasterizer: stream ports and config port.
// Instantiates hmr_ctrl and hmr_dp; uses hmr_pkg.
//
// Usage: each input beat carries one op in s_axis_tuser (clear, insert, query,
// read cell) with x, y, z and a cell index in s_axis_tdata. Every beat yields
// exactly one output beat: height in m_axis_tdata, out-of-range in m_axis_tuser.
// One beat is worked on at a time; s_axis_tready is high while the block idles.
// Steps after accept: insert and query run a setup step, two bit-serial
// dividers side by side, lookup, cell read and result; read cell runs
// lookup, cell read and result; clear sweeps the used cells, both counts
// clamped to the grid, one cell written per cycle through the single memory
// write port, then loads the result. The next beat can be taken in the cycle
// after the result loads.
// The result sits in an output register, so the next beat is accepted while
// it waits; when the receiver stalls, the following result holds in the
// finish state until the register frees up.
// Reset clears control and configuration; cell contents stay undefined until
// a clear op writes them. Config writes (cfg_we_i, cfg_idx_i, cfg_data_i)
// take effect at the clock edge and must only be issued while idle.
module height_map_max_rasterizer_top
  import hmr_pkg::*;
#(
  parameter int unsigned GRID_X_CELLS = 256,
  parameter int unsigned GRID_Y_CELLS = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // x_pos[31:0], y_pos[63:32], z_pos[95:64], cell_x[103:96], cell_y[111:104]
  input  logic [111:0]          s_axis_tdata,
  // op[1:0]
  input  logic [1:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // height_out[31:0]
  output logic [31:0]           m_axis_tdata,
  // out_of_range[0]
  output logic [0:0]            m_axis_tuser,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  hmr_cmd_t cmd;
  hmr_sts_t sts;
  logic signed [31:0] height_out;
  logic               out_of_range;

  hmr_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_op_i    (s_axis_tuser),
    .s_ready_o (s_axis_tready),
    .m_ready_i (m_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  hmr_dp #(
    .GRID_X_CELLS (GRID_X_CELLS),
    .GRID_Y_CELLS (GRID_Y_CELLS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .op_i           (s_axis_tuser),
    .x_pos_i        (s_axis_tdata[31:0]),
    .y_pos_i        (s_axis_tdata[63:32]),
    .z_pos_i        (s_axis_tdata[95:64]),
    .cell_x_i       (s_axis_tdata[103:96]),
    .cell_y_i       (s_axis_tdata[111:104]),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .height_out_o   (height_out),
    .out_of_range_o (out_of_range)
  );

  assign m_axis_tdata    = height_out;
  assign m_axis_tuser[0] = out_of_range;

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for height_map_max_rasterizer_top: drives op beats and grid settings,
// predicts each result beat from a local grid copy or a typed row. Depends on hmr_pkg.
module tb_top;
  import hmr_pkg::*;

  localparam int unsigned GRID_X        = 256;
  localparam int unsigned GRID_Y        = 256;
  localparam int unsigned STALL_LIMIT   = 300000;
  localparam int unsigned IDLE_GAP      = 8;
  localparam int unsigned HOLD_CYCLES   = 600;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned PHASE_BEATS   = 44;

  typedef struct packed {
    op_e         op;
    logic [31:0] x_pos;
    logic [31:0] y_pos;
    logic [31:0] z_pos;
    logic [7:0]  cell_x;
    logic [7:0]  cell_y;
  } beat_t;

  typedef struct packed {
    logic [31:0] height;
    logic        out_of_range;
  } result_t;

  typedef struct packed {
    logic [31:0] x_shift;
    logic [31:0] y_shift;
    logic [31:0] x_pitch;
    logic [31:0] y_pitch;
    logic [31:0] base_height;
    logic [31:0] used_cols;
    logic [31:0] used_rows;
  } grid_cfg_t;

  typedef struct packed {
    logic [1:0] setting;
    beat_t      beat;
    logic       typed;
    result_t    res;
  } table_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [111:0]          s_axis_tdata;
  logic [1:0]            s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [31:0]           m_axis_tdata;
  logic [0:0]            m_axis_tuser;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // Local copy of the grid settings and cell heights
  logic [31:0] cur_x_shift, cur_y_shift, cur_base_height;
  logic [30:0] cur_x_pitch, cur_y_pitch;
  logic [8:0]  cur_used_cols, cur_used_rows;
  logic [31:0] height_grid [GRID_X*GRID_Y];

  result_t     pending_heights [$];
  logic [63:0] recent_points [$];
  table_row_t  directed_rows [$];
  grid_cfg_t   corner_settings [1:2];

  bit          tight;
  bit          hold_request;
  int unsigned mismatch_count;
  int unsigned stuck_cycles;
  int unsigned op_count [4];
  int unsigned out_of_range_count;
  int unsigned settings_seen;

  height_map_max_rasterizer_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint used_cols_eff();
    return (cur_used_cols > GRID_X) ? GRID_X : longint'(cur_used_cols);
  endfunction

  function automatic longint used_rows_eff();
    return (cur_used_rows > GRID_Y) ? GRID_Y : longint'(cur_used_rows);
  endfunction

  // Cell index along one axis: exact ceiling of (pos + shift) / pitch, zero pitch acts as 1
  function automatic longint cell_along(logic [31:0] pos, logic [31:0] shift,
                                        logic [30:0] pitch);
    longint sum, div;
    sum = longint'($signed(pos)) + longint'($signed(shift));
    div = (pitch == '0) ? 64'sd1 : longint'(pitch);
    if (sum > 0) return (sum + div - 1) / div;
    return -((-sum) / div);
  endfunction

  // Apply one op to the local grid and return the result beat it must produce
  function automatic result_t rasterize_beat(beat_t b);
    result_t r;
    longint  cx, cy, ux, uy, idx;
    bit      in_use;
    r  = '0;
    ux = used_cols_eff();
    uy = used_rows_eff();
    if (b.op == OP_CLEAR) begin
      for (longint row = 0; row < ux; row++)
        for (longint col = 0; col < uy; col++)
          height_grid[row*GRID_Y + col] = cur_base_height;
      return r;
    end
    if (b.op == OP_READ) begin
      cx = b.cell_x;
      cy = b.cell_y;
    end else begin
      cx = cell_along(b.x_pos, cur_x_shift, cur_x_pitch);
      cy = cell_along(b.y_pos, cur_y_shift, cur_y_pitch);
    end
    in_use = (cx >= 0) && (cx < ux) && (cy >= 0) && (cy < uy);
    idx    = cx*GRID_Y + cy;
    if (!in_use) begin
      r.out_of_range = 1'b1;
      if (b.op != OP_INSERT) r.height = Q16_MINUS_ONE;
    end else if (b.op == OP_INSERT) begin
      if ($signed(b.z_pos) > $signed(height_grid[idx])) height_grid[idx] = b.z_pos;
    end else begin
      r.height = height_grid[idx];
    end
    return r;
  endfunction

  // Coordinate that lands near the used grid, with an edge cell beyond it now and then
  function automatic logic [31:0] pos_near_grid(logic [31:0] shift, logic [30:0] pitch,
                                                longint span);
    longint d, target, sum, pos;
    d = (pitch == '0) ? 64'sd1 : longint'(pitch);
    if ($urandom_range(99) < 25) return $urandom();
    target = longint'($urandom_range(32'(span) + 1)) - 1;
    sum    = (target - 1) * d + longint'($urandom_range(32'(d - 1))) + 1;
    pos    = sum - longint'($signed(shift));
    if (pos < -64'sd2147483648 || pos > 64'sd2147483647) return $urandom();
    return pos[31:0];
  endfunction

  function automatic logic [31:0] rand_pitch();
    logic [31:0] junk;
    junk = ($urandom_range(3) == 0) ? 32'h8000_0000 : 32'h0;
    case ($urandom_range(9))
      0:       return junk;
      1:       return $urandom_range(16, 1);
      2:       return $urandom();
      default: return $urandom_range(32'h3_0000, 32'h2000) | junk;
    endcase
  endfunction

  function automatic logic [31:0] rand_shift(logic [31:0] pitch);
    longint d, v;
    d = (pitch[30:0] == '0) ? 64'sd1 : longint'(pitch[30:0]);
    if (d > 64'sd268435456) d = 64'sd268435456;
    if ($urandom_range(99) < 25) return $urandom();
    v = longint'($urandom_range(32'(2*d))) - d;
    return v[31:0];
  endfunction

  function automatic logic [31:0] rand_used();
    logic [31:0] junk;
    junk = ($urandom_range(4) == 0) ? ($urandom() & 32'hFFFF_FE00) : 32'h0;
    case ($urandom_range(19))
      0:       return junk;
      1:       return $urandom_range(511, 257) | junk;
      default: return $urandom_range(24, 1) | junk;
    endcase
  endfunction

  function automatic beat_t random_beat(bit clear_ok);
    beat_t       b;
    int unsigned pick;
    longint      ux, uy;
    ux       = used_cols_eff();
    uy       = used_rows_eff();
    b.z_pos  = $urandom();
    b.cell_x = 8'($urandom());
    b.cell_y = 8'($urandom());
    b.x_pos  = pos_near_grid(cur_x_shift, cur_x_pitch, ux);
    b.y_pos  = pos_near_grid(cur_y_shift, cur_y_pitch, uy);
    pick     = $urandom_range(99);
    if (clear_ok && pick < 5)  b.op = OP_CLEAR;
    else if (pick < 45)        b.op = OP_INSERT;
    else if (pick < 72)        b.op = OP_QUERY;
    else                       b.op = OP_READ;
    // Revisit recently filled cells so queries see max-merged heights
    if (b.op == OP_QUERY && recent_points.size() != 0 && $urandom_range(99) < 40)
      {b.x_pos, b.y_pos} = recent_points[$urandom_range(recent_points.size() - 1)];
    if (b.op == OP_READ && ux > 0 && uy > 0 && $urandom_range(99) < 65) begin
      b.cell_x = 8'($urandom_range(32'(ux - 1)));
      b.cell_y = 8'($urandom_range(32'(uy - 1)));
    end
    if (b.op == OP_INSERT) begin
      recent_points.insert(recent_points.size(), {b.x_pos, b.y_pos});
      if (recent_points.size() > 16) void'(recent_points.pop_front());
    end
    return b;
  endfunction

  function automatic int unsigned sender_gap();
    int unsigned pick;
    if (tight) return 0;
    pick = $urandom_range(99);
    if (pick < 55) return 0;
    if (pick < 85) return $urandom_range(3, 1);
    if (pick < 97) return $urandom_range(15, 4);
    return $urandom_range(120, 30);
  endfunction

  // Write one register and mirror it into the local settings
  task automatic write_reg(cfg_reg_e idx, logic [31:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_X_OFFSET:  cur_x_shift     = data;
      REG_Y_OFFSET:  cur_y_shift     = data;
      REG_X_STEP:    cur_x_pitch     = data[30:0];
      REG_Y_STEP:    cur_y_pitch     = data[30:0];
      REG_FLOOR:     cur_base_height = data;
      REG_COLS_USED: cur_used_cols   = data[8:0];
      REG_ROWS_USED: cur_used_rows   = data[8:0];
      default: ;
    endcase
  endtask

  task automatic program_grid(grid_cfg_t g);
    write_reg(REG_X_OFFSET,  g.x_shift);
    write_reg(REG_Y_OFFSET,  g.y_shift);
    write_reg(REG_X_STEP,    g.x_pitch);
    write_reg(REG_Y_STEP,    g.y_pitch);
    write_reg(REG_FLOOR,     g.base_height);
    write_reg(REG_COLS_USED, g.used_cols);
    write_reg(REG_ROWS_USED, g.used_rows);
    cfg_we_i <= 1'b0;
    settings_seen++;
  endtask

  // Stop offering and hold until every result beat is back
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_heights.size() != 0) @(posedge clk_i);
    repeat (IDLE_GAP) @(posedge clk_i);
  endtask

  // Offer one beat, then record its expected result once it is taken
  task automatic offer_beat(beat_t b, bit typed, result_t typed_res);
    result_t     r;
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= b.op;
    s_axis_tdata  <= {b.cell_y, b.cell_x, b.z_pos, b.y_pos, b.x_pos};
    do @(posedge clk_i); while (!s_axis_tready);
    r = rasterize_beat(b);
    if (typed) r = typed_res;
    pending_heights.insert(pending_heights.size(), r);
    op_count[b.op]++;
    if (r.out_of_range) out_of_range_count++;
    gap = sender_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic add_row(logic [1:0] setting, op_e op, logic [31:0] x, logic [31:0] y,
                         logic [31:0] z, logic [7:0] cx, logic [7:0] cy, bit typed,
                         logic [31:0] height, bit flag);
    table_row_t t;
    t.setting = setting;
    t.beat    = '{op: op, x_pos: x, y_pos: y, z_pos: z, cell_x: cx, cell_y: cy};
    t.typed   = typed;
    t.res     = '{height: height, out_of_range: flag};
    directed_rows.insert(directed_rows.size(), t);
  endtask

  // Receiver: random stalls, a long hold on request, always ready in tight phases
  initial begin : receiver
    int unsigned pick;
    int unsigned run;
    m_axis_tready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_request) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_request = 1'b0;
      end else if (tight) begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end else begin
        pick = $urandom_range(99);
        if (pick < 60) begin
          m_axis_tready <= 1'b1;
          run = $urandom_range(16, 1);
        end else begin
          m_axis_tready <= 1'b0;
          if (pick < 88)      run = $urandom_range(4, 1);
          else if (pick < 97) run = $urandom_range(20, 5);
          else                run = $urandom_range(150, 40);
        end
        repeat (run) @(posedge clk_i);
      end
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_heights.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: unexpected result beat height=%h flag=%b", $time,
                   m_axis_tdata, m_axis_tuser[0]);
      end else begin
        want = pending_heights.pop_front();
        if (m_axis_tdata !== want.height || m_axis_tuser[0] !== want.out_of_range) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result mismatch height exp=%h got=%h flag exp=%b got=%b",
                     $time, want.height, m_axis_tdata, want.out_of_range, m_axis_tuser[0]);
        end
      end
    end
  end

  // Watchdog: end the run when no beat moves on either side for too long
  always @(posedge clk_i) begin : watchdog
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stuck_cycles = 0;
    else
      stuck_cycles++;
    if (stuck_cycles >= STALL_LIMIT) begin
      $display("%0t: watchdog, no beat moved for %0d cycles", $time, stuck_cycles);
      $display("height_map_max_rasterizer_top test failed");
      $finish;
    end
  end

  initial begin : stimulus
    beat_t     b;
    grid_cfg_t g;
    bit        clear_ok;
    logic [1:0] active_setting;

    rst_ni          <= 1'b0;
    s_axis_tvalid   <= 1'b0;
    s_axis_tdata    <= '0;
    s_axis_tuser    <= OP_CLEAR;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= REG_X_OFFSET;
    cfg_data_i      <= '0;
    tight           = 1'b0;
    hold_request    = 1'b0;
    mismatch_count  = 0;
    stuck_cycles    = 0;
    settings_seen   = 1;
    out_of_range_count = 0;
    foreach (op_count[i]) op_count[i] = 0;

    // Local settings start at the reset values
    cur_x_shift     = 32'd0;
    cur_y_shift     = 32'd0;
    cur_x_pitch     = 31'h1_0000;
    cur_y_pitch     = 31'h1_0000;
    cur_base_height = 32'd0;
    cur_used_cols   = 9'd256;
    cur_used_rows   = 9'd256;
    active_setting  = 2'd0;

    // Corner settings: extreme shifts, zero and widest pitch, clamped counts
    corner_settings[1] = '{x_shift: 32'h7FFF_FFFF, y_shift: 32'h8000_0000,
                           x_pitch: 32'h0, y_pitch: 32'hFFFF_FFFF,
                           base_height: 32'h8000_0000,
                           used_cols: 32'h1FF, used_rows: 32'h12C};
    // and a grid with no column in use
    corner_settings[2] = '{x_shift: 32'h0, y_shift: 32'h0,
                           x_pitch: 32'h1_0000, y_pitch: 32'h1_0000,
                           base_height: 32'h0042_0000,
                           used_cols: 32'h0, used_rows: 32'h5};

    // Reset settings: unit cells, full 256 x 256 grid, floor 0
    add_row(0, OP_CLEAR,  32'h0, 32'h0, 32'h0, 8'd0, 8'd0, 1, 32'h0, 0);
    add_row(0, OP_READ,   32'h0, 32'h0, 32'h0, 8'd0, 8'd0, 1, 32'h0, 0);
    add_row(0, OP_READ,   32'h0, 32'h0, 32'h0, 8'd255, 8'd255, 1, 32'h0, 0);
    add_row(0, OP_INSERT, 32'h0, 32'h0, 32'h7FFF_FFFF, 8'd0, 8'd0, 1, 32'h0, 0);
    add_row(0, OP_READ,   32'h0, 32'h0, 32'h0, 8'd0, 8'd0, 1, 32'h7FFF_FFFF, 0);
    // lower z than the stored floor must not win
    add_row(0, OP_INSERT, 32'h1_0000, 32'h2_0000, 32'hFFFF_FFFB, 8'd0, 8'd0, 1, 32'h0, 0);
    add_row(0, OP_QUERY,  32'h1_0000, 32'h2_0000, 32'h0, 8'd0, 8'd0, 1, 32'h0, 0);
    // half a cell below zero rounds up into cell 0
    add_row(0, OP_QUERY,  32'hFFFF_8000, 32'h0, 32'h0, 8'd0, 8'd0, 1, 32'h7FFF_FFFF, 0);
    add_row(0, OP_INSERT, 32'hFFFF_0000, 32'h0, 32'h5, 8'd0, 8'd0, 1, 32'h0, 1);
    add_row(0, OP_QUERY,  32'h7FFF_FFFF, 32'h0, 32'h0, 8'd0, 8'd0, 1, Q16_MINUS_ONE, 1);
    add_row(0, OP_QUERY,  32'h8000_0000, 32'h8000_0000, 32'h0, 8'd0, 8'd0, 1,
            Q16_MINUS_ONE, 1);
    add_row(0, OP_INSERT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 8'd0, 8'd0, 1,
            32'h0, 1);
    // smallest positive fraction lands in cell 1
    add_row(0, OP_INSERT, 32'h1, 32'h1, 32'h8000_0000, 8'd0, 8'd0, 1, 32'h0, 0);
    add_row(0, OP_INSERT, 32'h00FF_0000, 32'h00FF_0000, 32'h1234_5678, 8'd0, 8'd0, 1,
            32'h0, 0);
    add_row(0, OP_QUERY,  32'h00FE_0001, 32'h00FE_8000, 32'h0, 8'd0, 8'd0, 0, 32'h0, 0);
    add_row(0, OP_QUERY,  32'h00FF_0001, 32'h0, 32'h0, 8'd0, 8'd0, 1, Q16_MINUS_ONE, 1);
    add_row(0, OP_INSERT, 32'h0003_8000, 32'h0004_4000, 32'h0000_ABCD, 8'd0, 8'd0, 1,
            32'h0, 0);
    add_row(0, OP_QUERY,  32'h0003_1000, 32'h0004_F000, 32'h0, 8'd0, 8'd0, 0, 32'h0, 0);
    add_row(0, OP_READ,   32'h0, 32'h0, 32'h0, 8'd4, 8'd5, 0, 32'h0, 0);
    // Corner settings: clamped clear, wrap-free offset sums, oversized pitch
    add_row(1, OP_CLEAR,  32'h0, 32'h0, 32'h0, 8'd0, 8'd0, 1, 32'h0, 0);
    add_row(1, OP_READ,   32'h0, 32'h0, 32'h0, 8'd255, 8'd255, 1, 32'h8000_0000, 0);
    add_row(1, OP_QUERY,  32'h8000_0000, 32'h0, 32'h0, 8'd0, 8'd0, 0, 32'h0, 0);
    add_row(1, OP_INSERT, 32'h8000_00FF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'd0, 8'd0, 0,
            32'h0, 0);
    // Empty grid: nothing is in range and clear writes nothing
    add_row(2, OP_CLEAR,  32'h0, 32'h0, 32'h0, 8'd0, 8'd0, 1, 32'h0, 0);
    add_row(2, OP_READ,   32'h0, 32'h0, 32'h0, 8'd0, 8'd0, 1, Q16_MINUS_ONE, 1);
    add_row(2, OP_INSERT, 32'h0, 32'h0, 32'h7FFF_FFFF, 8'd0, 8'd0, 1, 32'h0, 1);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Walk the directed table, switching settings only while idle
    foreach (directed_rows[i]) begin
      if (directed_rows[i].setting != active_setting) begin
        wait_idle();
        active_setting = directed_rows[i].setting;
        program_grid(corner_settings[active_setting]);
      end
      offer_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].res);
    end

    // Backpressure: receiver holds off while beats keep coming
    wait_idle();
    program_grid('{x_shift: 32'h0, y_shift: 32'h0, x_pitch: 32'h1_0000,
                   y_pitch: 32'h1_0000, base_height: $urandom(),
                   used_cols: 32'd16, used_rows: 32'd16});
    b    = '0;
    b.op = OP_CLEAR;
    offer_beat(b, 1'b0, '0);
    tight        = 1'b1;
    hold_request = 1'b1;
    repeat (30) offer_beat(random_beat(1'b0), 1'b0, '0);
    wait_idle();
    tight = 1'b0;

    // Random phases, each under a fresh grid setting
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      g.x_pitch     = rand_pitch();
      g.y_pitch     = rand_pitch();
      g.x_shift     = rand_shift(g.x_pitch);
      g.y_shift     = rand_shift(g.y_pitch);
      g.base_height = $urandom();
      g.used_cols   = rand_used();
      g.used_rows   = rand_used();
      program_grid(g);
      // keep clear sweeps short; large grids only see inserts, queries and reads
      clear_ok = (used_cols_eff() * used_rows_eff() <= 1024);
      tight    = (phase % 4 == 2);
      if (clear_ok) begin
        b    = '0;
        b.op = OP_CLEAR;
        offer_beat(b, 1'b0, '0);
      end
      repeat (PHASE_BEATS) offer_beat(random_beat(clear_ok), 1'b0, '0);
    end
    tight = 1'b0;

    wait_idle();
    repeat (50) @(posedge clk_i);
    if (pending_heights.size() != 0) begin
      $display("%0d expected result beats never arrived", pending_heights.size());
      mismatch_count += pending_heights.size();
    end

    $display("covered %0d clear, %0d insert, %0d query, %0d read beats over %0d settings",
             op_count[OP_CLEAR], op_count[OP_INSERT], op_count[OP_QUERY],
             op_count[OP_READ], settings_seen);
    $display("%0d beats fell outside the used grid, %0d mismatches",
             out_of_range_count, mismatch_count);
    if (mismatch_count == 0)
      $display("height_map_max_rasterizer_top test passed");
    else
      $display("height_map_max_rasterizer_top test failed");
    $finish;
  end

endmodule
